/* hdl/assert_macros.svh */
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_ALWAYS(lbl, !(cond), msg)

`endif

/* hdl/rclg_pkg.sv */
// ----------------------------------------------------------------------------
// rclg_pkg
// types, constants and microcode program of the resize coefficient generator
// ----------------------------------------------------------------------------
package rclg_pkg;

    localparam int TERM_W = 5;
    localparam int ACC_W  = 12;
    localparam int WGT_W  = 8;
    localparam int WGT_SH = 7;
    localparam int IDX_W  = 5;
    localparam int PC_W   = 4;

    localparam logic [WGT_W-1:0] W_ONE  = 8'd128;
    localparam logic [WGT_W-1:0] W_HALF = 8'd64;
    localparam logic [WGT_W-1:0] W_ZERO = 8'd0;

    typedef logic [PC_W-1:0] t_pc;

    // program addresses
    localparam t_pc ST_IDLE     = 4'd0;
    localparam t_pc ST_CHK      = 4'd1;
    localparam t_pc ST_UP_MOD   = 4'd2;
    localparam t_pc ST_UP_MODW  = 4'd3;
    localparam t_pc ST_UP_WGT   = 4'd4;
    localparam t_pc ST_UP_WGTW  = 4'd5;
    localparam t_pc ST_UP_EMIT  = 4'd6;
    localparam t_pc ST_DN_MOD   = 4'd7;
    localparam t_pc ST_DN_MODW  = 4'd8;
    localparam t_pc ST_DN_WGT   = 4'd9;
    localparam t_pc ST_DN_WGTW  = 4'd10;
    localparam t_pc ST_DN_EMIT  = 4'd11;
    localparam t_pc ST_DN1_EMIT = 4'd12;

    typedef enum logic [2:0] {
        DS_NONE,
        DS_IN,
        DS_TN,
        DS_WUP,
        DS_WDN
    } t_dsrc;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_UP,
        EM_DN,
        EM_DN1
    } t_emit;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_INPUT,
        JC_DISPATCH,
        JC_ENTRY,
        JC_HOME
    } t_jc;

    typedef struct packed {
        t_dsrc div_src;
        logic  div_wait;
        t_emit emit;
        t_jc   jc;
        t_pc   target;
    } t_ucw;

    typedef struct packed {
        logic in_valid;
        logic is_up;
        logic m_one;
        logic len_zero;
        logic last;
        logic div_busy;
        logic out_stall;
    } t_stat;

    function automatic t_ucw ucode_rom(input t_pc pc);
        t_ucw w;
        w = '{div_src: DS_NONE, div_wait: 1'b0, emit: EM_NONE, jc: JC_NEXT,
              target: ST_IDLE};
        unique case (pc)
            ST_IDLE:     w.jc = JC_INPUT;
            ST_CHK:      w.jc = JC_DISPATCH;
            ST_UP_MOD:   w.div_src = DS_IN;
            ST_UP_MODW:  w.div_wait = 1'b1;
            ST_UP_WGT:   w.div_src = DS_WUP;
            ST_UP_WGTW:  w.div_wait = 1'b1;
            ST_UP_EMIT: begin
                w.emit   = EM_UP;
                w.jc     = JC_ENTRY;
                w.target = ST_UP_MOD;
            end
            ST_DN_MOD:   w.div_src = DS_TN;
            ST_DN_MODW:  w.div_wait = 1'b1;
            ST_DN_WGT:   w.div_src = DS_WDN;
            ST_DN_WGTW:  w.div_wait = 1'b1;
            ST_DN_EMIT: begin
                w.emit   = EM_DN;
                w.jc     = JC_ENTRY;
                w.target = ST_DN_MOD;
            end
            ST_DN1_EMIT: begin
                w.emit   = EM_DN1;
                w.jc     = JC_ENTRY;
                w.target = ST_DN1_EMIT;
            end
            default:     w.jc = JC_HOME;
        endcase
        return w;
    endfunction

endpackage

/* hdl/rclg_div.sv */
// ----------------------------------------------------------------------------
// rclg_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rclg_div
    import rclg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_dividend,
    input  logic [TERM_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [ACC_W-1:0]  o_quo,
    output logic [TERM_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_q, n_q;
    logic [TERM_W-1:0] r_rem, n_rem;
    logic [TERM_W-1:0] r_div, n_div;
    logic [TERM_W:0]   w_trial;
    logic [TERM_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_q[ACC_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ACC_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[TERM_W-1:0];
                n_q   = {r_q[ACC_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[TERM_W-1:0];
                n_q   = {r_q[ACC_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_busy = (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

    `ASSERT_NEVER(a_start_busy, i_start && r_busy, "divider started while busy")
    `ASSERT_ALWAYS(a_cnt_busy, r_busy |-> r_cnt != '0, "busy with no bits left")

endmodule

/* hdl/rclg_seq.sv */
// ----------------------------------------------------------------------------
// rclg_seq
// step counter and microcode rom with stall and jump handling
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rclg_seq
    import rclg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ucw  o_ucw,
    output logic  o_go
);

    t_pc  r_pc, n_pc;
    t_ucw w_ucw;
    logic w_go;

    always_comb begin
        w_ucw = ucode_rom(r_pc);
        w_go  = !(w_ucw.div_wait && i_stat.div_busy)
             && !((w_ucw.emit != EM_NONE) && i_stat.out_stall)
             && !((w_ucw.jc == JC_INPUT) && !i_stat.in_valid);
        n_pc  = r_pc;
        if (w_go) begin
            unique case (w_ucw.jc)
                JC_NEXT:  n_pc = r_pc + 1'b1;
                JC_INPUT: n_pc = ST_CHK;
                JC_DISPATCH: begin
                    priority if (i_stat.len_zero) n_pc = ST_IDLE;
                    else if (i_stat.is_up)        n_pc = ST_UP_MOD;
                    else if (i_stat.m_one)        n_pc = ST_DN1_EMIT;
                    else                          n_pc = ST_DN_MOD;
                end
                JC_ENTRY: n_pc = i_stat.last ? ST_IDLE : w_ucw.target;
                JC_HOME:  n_pc = ST_IDLE;
                default:  n_pc = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ucw = w_ucw;
    assign o_go  = w_go;

    `ASSERT_ALWAYS(a_accept_chk, (w_go && w_ucw.jc == JC_INPUT) |=> r_pc == ST_CHK,
        "accepted item not followed by dispatch")

endmodule

/* hdl/resize_coef_lut_gen.sv */
// each entry takes two passes through the 12-bit serial divider (remainder,
// then weight); a downscale table with M of one needs no division and gives
// one entry per cycle while the output is not stalled
// next item is taken once the last entry sits in the output register
// reset: synchronous active low, returns the program to its idle step
// ----------------------------------------------------------------------------
// resize_coef_lut_gen
// bilinear resize lookup table generator, microcoded over a shared divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module resize_coef_lut_gen
    import rclg_pkg::*;
#(
    parameter int LUT_DEPTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // src_n, dst_m, zero fill
    input  logic        i_s_axis_tuser,   // upscale
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // entry_index, weight, take_input,
                                          // emit_output, zero fill
    output logic        o_m_axis_tlast    // last_entry
);

    localparam int LEN_W = $clog2(LUT_DEPTH + 1);

    t_ucw w_ucw;
    t_stat w_stat;
    logic w_go;

    logic [TERM_W-1:0] r_n, r_m;
    logic              r_up;
    logic [LEN_W-1:0]  r_len, r_i;
    logic [ACC_W-1:0]  r_in, r_im, r_tn, r_tm, r_xn;

    logic              r_ovalid;
    logic [IDX_W-1:0]  r_oidx;
    logic [WGT_W-1:0]  r_owgt;
    logic              r_otin, r_otout, r_olast;

    logic [TERM_W-1:0] w_in_n, w_in_m;
    logic [TERM_W-1:0] w_len_raw;
    logic [LEN_W-1:0]  w_len;

    logic              w_div_start;
    logic [ACC_W-1:0]  w_dividend;
    logic              w_div_busy;
    logic [ACC_W-1:0]  w_quo;
    logic [TERM_W-1:0] w_rem;

    logic              w_last, w_skip, w_eq, w_noout, w_tin_up;
    logic [ACC_W-1:0]  w_tn1, w_im_next;
    logic [WGT_W-1:0]  w_wgt;
    logic              w_tin, w_tout;

    assign w_in_n = i_s_axis_tdata[4:0];
    assign w_in_m = i_s_axis_tdata[9:5];

    always_comb begin
        if (i_s_axis_tuser) begin
            w_len_raw = w_in_m;
        end else if (w_in_m == '0) begin
            w_len_raw = '0;
        end else begin
            w_len_raw = w_in_n;
        end
        if (32'(w_len_raw) > LUT_DEPTH) begin
            w_len = LEN_W'(LUT_DEPTH);
        end else begin
            w_len = LEN_W'(w_len_raw);
        end
    end

    assign w_last    = (r_i + 1'b1) == r_len;
    assign w_tn1     = r_tn + 1'b1;
    assign w_im_next = r_im + ACC_W'(r_m);
    assign w_skip    = w_tn1 >= w_im_next;
    assign w_eq      = w_tn1 == r_im;
    assign w_noout   = (r_xn + 1'b1) >= w_im_next;
    assign w_tin_up  = r_tm <= r_in;

    assign w_stat = '{
        in_valid:  i_s_axis_tvalid,
        is_up:     r_up,
        m_one:     r_m == TERM_W'(1),
        len_zero:  r_len == '0,
        last:      w_last,
        div_busy:  w_div_busy,
        out_stall: r_ovalid && !i_m_axis_tready
    };

    rclg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ucw   (w_ucw),
        .o_go    (w_go)
    );

    always_comb begin
        unique case (w_ucw.div_src)
            DS_IN:   w_dividend = r_in;
            DS_TN:   w_dividend = r_tn;
            DS_WUP:  w_dividend = ACC_W'(r_m - w_rem) << WGT_SH;
            DS_WDN:  w_dividend = ACC_W'(r_m - 1'b1 - w_rem) << WGT_SH;
            default: w_dividend = '0;
        endcase
        w_div_start = w_go && (w_ucw.div_src != DS_NONE);
    end

    rclg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_m),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    always_comb begin
        unique case (w_ucw.emit)
            EM_UP: begin
                w_wgt  = w_quo[WGT_W-1:0];
                w_tin  = w_tin_up;
                w_tout = 1'b1;
            end
            EM_DN: begin
                priority if (w_skip) w_wgt = W_ZERO;
                else if (w_eq)       w_wgt = W_ONE;
                else                 w_wgt = w_quo[WGT_W-1:0];
                w_tin  = 1'b1;
                w_tout = !w_noout;
            end
            EM_DN1: begin
                w_wgt  = (r_i == '0) ? W_HALF : W_ZERO;
                w_tin  = 1'b1;
                w_tout = (r_i == '0);
            end
            default: begin
                w_wgt  = W_ZERO;
                w_tin  = 1'b0;
                w_tout = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_ucw.jc == JC_INPUT) begin
            r_n   <= w_in_n;
            r_m   <= w_in_m;
            r_up  <= i_s_axis_tuser;
            r_len <= w_len;
            r_i   <= '0;
            r_in  <= '0;
            r_im  <= '0;
            r_tn  <= '0;
            r_tm  <= '0;
            r_xn  <= '0;
        end else if (w_go && w_ucw.emit != EM_NONE) begin
            r_i  <= r_i + 1'b1;
            r_in <= r_in + ACC_W'(r_n);
            r_im <= w_im_next;
            if (w_ucw.emit == EM_UP && w_tin_up) begin
                r_tm <= r_tm + ACC_W'(r_m);
            end
            if (w_ucw.emit == EM_DN && !w_skip) begin
                r_tn <= r_tn + ACC_W'(r_n);
            end
            if (w_ucw.emit == EM_DN && !w_noout) begin
                r_xn <= r_xn + ACC_W'(r_n);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_go && w_ucw.emit != EM_NONE) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (w_go && w_ucw.emit != EM_NONE) begin
            r_oidx  <= IDX_W'(r_i);
            r_owgt  <= w_wgt;
            r_otin  <= w_tin;
            r_otout <= w_tout;
            r_olast <= w_last;
        end
    end

    assign o_s_axis_tready = (w_ucw.jc == JC_INPUT);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_otout, r_otin, r_owgt, r_oidx};
    assign o_m_axis_tlast  = r_olast;

    `ASSERT_ALWAYS(a_idx_range, (w_go && w_ucw.emit != EM_NONE) |-> r_i < r_len,
        "entry issued past end of table")
    `ASSERT_NEVER(a_emit_up_mode, w_go && w_ucw.emit == EM_UP && !r_up,
        "upscale entry issued for a downscale table")

endmodule
